// ----- hw/rtl/lpfr_pkg.sv -----
// Shared types and constants for the length-prefixed frame receiver.
// No dependencies; all other files but lpfr_ram import this package.
package lpfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 9;
  localparam int IDX_OUT_W = 5;
  localparam int FLEN_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 1'b1;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h28;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h29;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } lpfr_cmd_t;

endpackage

// ----- hw/rtl/length_prefixed_frame_receiver_top.sv -----
// Top level of the length-prefixed frame receiver: front end, command queue,
// drain engine and two-bank payload RAM. Depends on lpfr_pkg and every lpfr_* design module.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_stall   in_rx_byte
//   out       output     out_valid / out_stall out_payload_byte, out_payload_index,
//                                              out_frame_length, out_last
//   cfg       input      cfg_we                cfg_index, cfg_wdata
//
// A received byte is taken whenever in_stall is low; in_stall rises only while two
// completed frames wait to be drained, one in each RAM bank.
// A completed frame of N payload bytes leaves as N transactions; the single RAM read
// port takes no new read while the registered data of the previous one is pending.
// Reset is synchronous and needs no clearing pass; out_stall holds the output
// register and in time the drain engine, never the front end directly.
module length_prefixed_frame_receiver_top #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lpfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpfr_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lpfr_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lpfr_pkg::BYTE_W-1:0]       out_payload_byte,
  output logic [lpfr_pkg::IDX_OUT_W-1:0]    out_payload_index,
  output logic [lpfr_pkg::FLEN_W-1:0]       out_frame_length,
  output logic                              out_last
);
  import lpfr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic              q_full, q_head_valid, push, pop, ram_we;
  lpfr_cmd_t         push_cmd, head_cmd;
  logic [AW:0]       ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  assign in_stall = q_full;

  lpfr_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_take   (in_valid && !q_full),
    .in_rx_byte(in_rx_byte),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  lpfr_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_valid(q_head_valid),
    .head_cmd  (head_cmd),
    .full      (q_full)
  );

  lpfr_ram #(.WIDTH(BYTE_W), .DEPTH(2 ** (AW + 1))) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lpfr_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_cmd         (head_cmd),
    .pop              (pop),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_payload_index(out_payload_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

endmodule

// ----- hw/rtl/lpfr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/lpfr_front.sv -----
// Front end: holds the code registers, classifies received bytes, stores payload
// bytes and posts a drain command per completed frame. Depends on lpfr_pkg.
module lpfr_front #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [lpfr_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [lpfr_pkg::BYTE_W-1:0]               cfg_wdata,
  input  logic                                      in_take,
  input  logic [lpfr_pkg::BYTE_W-1:0]               in_rx_byte,
  output logic                                      ram_we,
  output logic [$clog2(BUFFER_DEPTH):0]             ram_waddr,
  output logic [lpfr_pkg::BYTE_W-1:0]               ram_wdata,
  output logic                                      push,
  output lpfr_pkg::lpfr_cmd_t                       push_cmd
);
  import lpfr_pkg::*;

  localparam int AW      = $clog2(BUFFER_DEPTH);
  localparam int CW      = $clog2(BUFFER_DEPTH + 1);
  localparam int LEN_LIM = BUFFER_DEPTH + 1;

  logic [BYTE_W-1:0] start_code_r, end_code_r;
  logic              capturing_r, capturing_nxt;
  logic [CW-1:0]     exp_r, exp_nxt;
  logic [CW-1:0]     stored_r, stored_nxt;
  logic              wbank_r, wbank_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      end_code_r   <= END_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_CODE: start_code_r <= cfg_wdata;
        CFG_END_CODE:   end_code_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    capturing_nxt = capturing_r;
    exp_nxt       = exp_r;
    stored_nxt    = stored_r;
    wbank_nxt     = wbank_r;
    ram_we        = 1'b0;
    push          = 1'b0;
    if (in_take) begin
      if (exp_r == '0) begin
        if (in_rx_byte == start_code_r) begin
          capturing_nxt = 1'b1;
          stored_nxt    = '0;
        end else if (capturing_r) begin
          if (in_rx_byte == '0 || int'(in_rx_byte) > LEN_LIM) begin
            capturing_nxt = 1'b0;
          end else begin
            exp_nxt = CW'(in_rx_byte) - CW'(1);
          end
        end
      end else if (stored_r >= exp_r) begin
        if (in_rx_byte == end_code_r) begin
          push      = 1'b1;
          wbank_nxt = ~wbank_r;
        end
        capturing_nxt = 1'b0;
        exp_nxt       = '0;
      end else begin
        ram_we     = 1'b1;
        stored_nxt = stored_r + CW'(1);
      end
    end
  end

  assign ram_waddr     = {wbank_r, stored_r[AW-1:0]};
  assign ram_wdata     = in_rx_byte;
  assign push_cmd.bank = wbank_r;
  assign push_cmd.len  = LEN_W'(stored_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      exp_r       <= '0;
      stored_r    <= '0;
      wbank_r     <= 1'b0;
    end else begin
      capturing_r <= capturing_nxt;
      exp_r       <= exp_nxt;
      stored_r    <= stored_nxt;
      wbank_r     <= wbank_nxt;
    end
  end

endmodule

// ----- hw/rtl/lpfr_cmdq.sv -----
// Two-entry command queue between the front end and the drain engine.
// Depends on lpfr_pkg for the command type.
module lpfr_cmdq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpfr_pkg::lpfr_cmd_t push_cmd,
  input  logic                pop,
  output logic                head_valid,
  output lpfr_pkg::lpfr_cmd_t head_cmd,
  output logic                full
);
  import lpfr_pkg::*;

  lpfr_cmd_t   ent_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = ent_r[rptr_r];
  assign full       = (cnt_r == 2'd2);

endmodule

// ----- hw/rtl/lpfr_back.sv -----
// Drain engine: walks the stored payload of each queued frame through the RAM
// read port into the output register. Depends on lpfr_pkg.
module lpfr_back #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               head_valid,
  input  lpfr_pkg::lpfr_cmd_t                head_cmd,
  output logic                               pop,
  output logic [$clog2(BUFFER_DEPTH):0]      ram_raddr,
  input  logic [lpfr_pkg::BYTE_W-1:0]        ram_rdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lpfr_pkg::BYTE_W-1:0]        out_payload_byte,
  output logic [lpfr_pkg::IDX_OUT_W-1:0]     out_payload_index,
  output logic [lpfr_pkg::FLEN_W-1:0]        out_frame_length,
  output logic                               out_last
);
  import lpfr_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [AW-1:0]        idx_r;
  logic                 rd_pend_r;
  logic [AW-1:0]        m_idx_r;
  logic [LEN_W-1:0]     m_len_r;
  logic                 m_last_r;
  logic                 out_valid_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [FLEN_W-1:0]    out_len_r;
  logic                 out_last_r;
  logic                 issue;
  logic                 is_last;

  assign issue     = head_valid && !rd_pend_r && (!out_valid_r || !out_stall);
  assign is_last   = (LEN_W'(idx_r) == head_cmd.len - LEN_W'(1));
  assign pop       = issue && is_last;
  assign ram_raddr = {head_cmd.bank, idx_r};

  always_ff @(posedge clk) begin
    if (issue) begin
      m_idx_r  <= idx_r;
      m_len_r  <= head_cmd.len;
      m_last_r <= is_last;
    end
    if (rd_pend_r) begin
      out_byte_r <= ram_rdata;
      out_idx_r  <= IDX_OUT_W'(m_idx_r);
      out_len_r  <= FLEN_W'(m_len_r);
      out_last_r <= m_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= issue;
      if (issue) begin
        idx_r <= is_last ? '0 : idx_r + AW'(1);
      end
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_byte_r;
  assign out_payload_index = out_idx_r;
  assign out_frame_length  = out_len_r;
  assign out_last          = out_last_r;

endmodule

// ----- hw/rtl/lpfr_checker.sv -----
// Port-level checker for the length-prefixed frame receiver, bound to the top level.
// Depends on lpfr_pkg and length_prefixed_frame_receiver_top.
module lpfr_checker #(
  parameter int BUFFER_DEPTH = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_we,
  input logic [lpfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [lpfr_pkg::BYTE_W-1:0]       cfg_wdata,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [lpfr_pkg::BYTE_W-1:0]       in_rx_byte,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [lpfr_pkg::BYTE_W-1:0]       out_payload_byte,
  input logic [lpfr_pkg::IDX_OUT_W-1:0]    out_payload_index,
  input logic [lpfr_pkg::FLEN_W-1:0]       out_frame_length,
  input logic                              out_last
);
  import lpfr_pkg::*;

  localparam bit SMALL_BUF = (BUFFER_DEPTH <= 32);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_payload_index) && $stable(out_frame_length) && $stable(out_last))
    else $error("Stalled output transaction changed.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Output valid right after reset.");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    SMALL_BUF && out_valid |-> (FLEN_W'(out_payload_index) < out_frame_length))
    else $error("Payload index beyond frame length.");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    SMALL_BUF && out_valid |->
      (out_last == (FLEN_W'(out_payload_index) == out_frame_length - FLEN_W'(1))))
    else $error("Last flag does not match the final payload position.");

endmodule

bind length_prefixed_frame_receiver_top lpfr_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_lpfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index),
  .cfg_wdata        (cfg_wdata),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_payload_byte (out_payload_byte),
  .out_payload_index(out_payload_index),
  .out_frame_length (out_frame_length),
  .out_last         (out_last)
);
